[design/peu_pkg.sv]
package peu_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned IN_TDATA_W  = 256;
    localparam int unsigned OUT_TDATA_W = 224;
    localparam int unsigned DRAW_SHIFT  = 24;

    localparam logic [31:0] RNG_DEFAULT = 32'h9E37_79B9;

    // Reset values of the configuration registers.
    localparam logic        RST_MODE         = 1'b0;
    localparam logic [16:0] RST_TIME_STEP    = 17'd1092;
    localparam logic [30:0] RST_SPAWN_WIDTH  = 31'd655360;
    localparam logic [31:0] RST_SPAWN_HEIGHT = 32'd655360;
    localparam logic [30:0] RST_SPAWN_DEPTH  = 31'd65536;
    localparam logic [31:0] RST_GRAVITY_Y    = 32'hFFF6_3333;
    localparam logic [16:0] RST_DAMPING      = 17'd64880;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE,
        REG_TIME_STEP,
        REG_SPAWN_WIDTH,
        REG_SPAWN_HEIGHT,
        REG_SPAWN_DEPTH,
        REG_GRAVITY_Y,
        REG_DAMPING,
        REG_RNG_SEED
    } cfg_reg_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_VX_DT,
        MUL_VY_DT,
        MUL_VZ_DT,
        MUL_G_DT,
        MUL_VX_DAMP,
        MUL_VY_DAMP,
        MUL_VZ_DAMP,
        MUL_RAND_W,
        MUL_RAND_D
    } mul_op_t;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_PX_ADD,
        WB_PY_ADD,
        WB_PZ_ADD,
        WB_VY_ADD,
        WB_VX_SET,
        WB_VY_SET,
        WB_VZ_SET,
        WB_PX_DRAW,
        WB_PZ_DRAW
    } wb_op_t;

    typedef struct packed {
        logic    load;
        mul_op_t mul_op;
        wb_op_t  wb_op;
        logic    age_upd;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic dt_zero;
        logic mode;
        logic py_neg;
    } dp_stat_t;

    function automatic logic signed [31:0] sat_wide(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v[63:31] == {33{1'b0}} || v[63:31] == {33{1'b1}}) begin
            r = v[31:0];
        end else if (v[63]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        logic signed [31:0] r;
        s = {a[31], a} + {b[31], b};
        if (s[32] == s[31]) begin
            r = s[31:0];
        end else if (s[32]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic [31:0] xorshift32(input logic [31:0] s_in);
        logic [31:0] s;
        s = s_in;
        s = s ^ (s << 13);
        s = s ^ (s >> 17);
        s = s ^ (s << 5);
        if (s == 32'd0) begin
            s = RNG_DEFAULT;
        end
        return s;
    endfunction

endpackage

[design/peu_ctrl.sv]
module peu_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  peu_pkg::dp_stat_t stat,
    output peu_pkg::dp_cmd_t  cmd
);
    import peu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_DRAW2,
        S_DRAW3,
        S_SPL2,
        S_SPL3,
        S_SPL4,
        S_SPL5,
        S_OUT
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    // Each state issues at most one multiply and writes back the one before, if any.
    always_comb begin
        cmd = '{load: 1'b0, mul_op: MUL_NONE, wb_op: WB_NONE, age_upd: 1'b0,
                out_load: 1'b0};
        case (state_reg)
            S_IDLE: begin
                cmd.load = s_tvalid;
            end
            S_MUL1: begin
                cmd.mul_op  = MUL_VX_DT;
                cmd.age_upd = stat.mode;
            end
            S_MUL2: begin
                cmd.mul_op = MUL_VY_DT;
                cmd.wb_op  = WB_PX_ADD;
            end
            S_MUL3: begin
                cmd.mul_op = MUL_VZ_DT;
                cmd.wb_op  = WB_PY_ADD;
            end
            S_MUL4: begin
                cmd.wb_op = WB_PZ_ADD;
                if (stat.mode) begin
                    cmd.mul_op = MUL_G_DT;
                end else if (stat.py_neg) begin
                    cmd.mul_op = MUL_RAND_W;
                end
            end
            S_DRAW2: begin
                cmd.mul_op = MUL_RAND_D;
                cmd.wb_op  = WB_PX_DRAW;
            end
            S_DRAW3: begin
                cmd.wb_op = WB_PZ_DRAW;
            end
            S_SPL2: begin
                cmd.mul_op = MUL_VX_DAMP;
                cmd.wb_op  = WB_VY_ADD;
            end
            S_SPL3: begin
                cmd.mul_op = MUL_VY_DAMP;
                cmd.wb_op  = WB_VX_SET;
            end
            S_SPL4: begin
                cmd.mul_op = MUL_VZ_DAMP;
                cmd.wb_op  = WB_VY_SET;
            end
            S_SPL5: begin
                cmd.wb_op = WB_VZ_SET;
            end
            S_OUT: begin
                cmd.out_load = out_free;
            end
            default: begin
                cmd.load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= stat.dt_zero ? S_OUT : S_MUL1;
                    end
                end
                S_MUL1:  state_reg <= S_MUL2;
                S_MUL2:  state_reg <= S_MUL3;
                S_MUL3:  state_reg <= S_MUL4;
                S_MUL4: begin
                    if (stat.mode) begin
                        state_reg <= S_SPL2;
                    end else if (stat.py_neg) begin
                        state_reg <= S_DRAW2;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_DRAW2: state_reg <= S_DRAW3;
                S_DRAW3: state_reg <= S_OUT;
                S_SPL2:  state_reg <= S_SPL3;
                S_SPL3:  state_reg <= S_SPL4;
                S_SPL4:  state_reg <= S_SPL5;
                S_SPL5:  state_reg <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[design/peu_dp.sv]
module peu_dp #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [peu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [peu_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [peu_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,
    input  peu_pkg::dp_cmd_t                   cmd,
    output peu_pkg::dp_stat_t                  stat,
    output logic [peu_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);
    import peu_pkg::*;

    localparam logic signed [31:0] DEAD_AGE = ~((32'sd1 <<< FRAC_BITS) - 32'sd1);

    logic               mode_reg;
    logic [16:0]        time_step_reg;
    logic [30:0]        spawn_width_reg;
    logic signed [31:0] spawn_height_reg;
    logic [30:0]        spawn_depth_reg;
    logic signed [31:0] gravity_y_reg;
    logic [16:0]        damping_reg;
    logic [31:0]        rng_reg;

    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [31:0] vx_reg, vy_reg, vz_reg;
    logic signed [31:0] age_reg;
    logic [30:0]        max_age_reg;
    logic               last_reg;
    logic               resp_reg;

    logic signed [63:0] prod_reg;
    logic signed [31:0] mul_a, mul_b;
    logic signed [31:0] dt_s, damp_s;
    logic [31:0]        rng_next;
    logic signed [31:0] draw_u;
    logic signed [31:0] q_frac, q_draw;
    logic signed [31:0] age_sum;
    logic signed [32:0] age_cmp_a, age_cmp_b;

    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tuser_reg;
    logic                   m_tlast_reg;

    assign dt_s   = {15'd0, time_step_reg};
    assign damp_s = {15'd0, damping_reg};

    // Top 24 bits of the draw minus one half: flipping the top bit recenters it.
    assign rng_next = xorshift32(rng_reg);
    assign draw_u   = {{8{~rng_next[31]}}, ~rng_next[31], rng_next[30:8]};

    assign q_frac = sat_wide(prod_reg >>> FRAC_BITS);
    assign q_draw = sat_wide(prod_reg >>> DRAW_SHIFT);

    assign age_sum   = add_sat(age_reg, dt_s);
    assign age_cmp_a = {age_sum[31], age_sum};
    assign age_cmp_b = {2'b00, max_age_reg};

    assign stat.dt_zero = (time_step_reg == 17'd0);
    assign stat.mode    = mode_reg;
    assign stat.py_neg  = py_reg[31];

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;
    assign m_tlast = m_tlast_reg;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            MUL_VX_DT: begin
                mul_a = vx_reg;
                mul_b = dt_s;
            end
            MUL_VY_DT: begin
                mul_a = vy_reg;
                mul_b = dt_s;
            end
            MUL_VZ_DT: begin
                mul_a = vz_reg;
                mul_b = dt_s;
            end
            MUL_G_DT: begin
                mul_a = gravity_y_reg;
                mul_b = dt_s;
            end
            MUL_VX_DAMP: begin
                mul_a = vx_reg;
                mul_b = damp_s;
            end
            MUL_VY_DAMP: begin
                mul_a = vy_reg;
                mul_b = damp_s;
            end
            MUL_VZ_DAMP: begin
                mul_a = vz_reg;
                mul_b = damp_s;
            end
            MUL_RAND_W: begin
                mul_a = draw_u;
                mul_b = {1'b0, spawn_width_reg};
            end
            MUL_RAND_D: begin
                mul_a = draw_u;
                mul_b = {1'b0, spawn_depth_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Configuration registers and the generator state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= RST_MODE;
            time_step_reg    <= RST_TIME_STEP;
            spawn_width_reg  <= RST_SPAWN_WIDTH;
            spawn_height_reg <= RST_SPAWN_HEIGHT;
            spawn_depth_reg  <= RST_SPAWN_DEPTH;
            gravity_y_reg    <= RST_GRAVITY_Y;
            damping_reg      <= RST_DAMPING;
            rng_reg          <= RNG_DEFAULT;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_MODE:         mode_reg         <= cfg_wdata[0];
                REG_TIME_STEP:    time_step_reg    <= cfg_wdata[16:0];
                REG_SPAWN_WIDTH:  spawn_width_reg  <= cfg_wdata[30:0];
                REG_SPAWN_HEIGHT: spawn_height_reg <= cfg_wdata;
                REG_SPAWN_DEPTH:  spawn_depth_reg  <= cfg_wdata[30:0];
                REG_GRAVITY_Y:    gravity_y_reg    <= cfg_wdata;
                REG_DAMPING:      damping_reg      <= cfg_wdata[16:0];
                REG_RNG_SEED: begin
                    rng_reg <= (cfg_wdata == 32'd0) ? RNG_DEFAULT : cfg_wdata;
                end
                default: mode_reg <= mode_reg;
            endcase
        end else if (cmd.mul_op == MUL_RAND_W || cmd.mul_op == MUL_RAND_D) begin
            rng_reg <= rng_next;
        end
    end

    // Working record, shared multiplier and output beat.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;

        if (cmd.load) begin
            px_reg      <= s_tdata[31:0];
            py_reg      <= s_tdata[63:32];
            pz_reg      <= s_tdata[95:64];
            vx_reg      <= s_tdata[127:96];
            vy_reg      <= s_tdata[159:128];
            vz_reg      <= s_tdata[191:160];
            age_reg     <= s_tdata[223:192];
            max_age_reg <= s_tdata[254:224];
            last_reg    <= s_tlast;
            resp_reg    <= 1'b0;
        end else begin
            case (cmd.wb_op)
                WB_PX_ADD: px_reg <= add_sat(px_reg, q_frac);
                WB_PY_ADD: py_reg <= add_sat(py_reg, q_frac);
                WB_PZ_ADD: pz_reg <= add_sat(pz_reg, q_frac);
                WB_VY_ADD: vy_reg <= add_sat(vy_reg, q_frac);
                WB_VX_SET: vx_reg <= q_frac;
                WB_VY_SET: vy_reg <= q_frac;
                WB_VZ_SET: vz_reg <= q_frac;
                WB_PX_DRAW: begin
                    px_reg   <= q_draw;
                    py_reg   <= spawn_height_reg;
                    resp_reg <= 1'b1;
                end
                WB_PZ_DRAW: pz_reg <= q_draw;
                default: px_reg <= px_reg;
            endcase
            if (cmd.age_upd) begin
                age_reg <= (age_cmp_a >= age_cmp_b) ? DEAD_AGE : age_sum;
            end
        end

        if (cmd.out_load) begin
            m_tdata_reg <= {age_reg, vz_reg, vy_reg, vx_reg, pz_reg, py_reg, px_reg};
            m_tuser_reg <= resp_reg;
            m_tlast_reg <= last_reg;
        end
    end

endmodule

[design/particle_euler_update.sv]
// Explicit Euler update of particle records in signed fixed point.
// Input stream: one beat per particle on s_tdata with s_tlast marking the
// last particle of a batch. Output stream: one beat per particle with the
// updated record, m_tuser set for a respawned particle and m_tlast copied.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata, by the
// user only while the block is idle, which the block does not enforce;
// writing the seed register reloads the random generator. A controller
// steps a datapath built around one shared 32x32 multiplier whose product
// is registered before it is scaled and written back. An item goes through
// accept, one state per multiply, a final write-back when anything was
// multiplied, and the output load; a zero time step skips the multiplies,
// and respawn and splash add multiplies to the waterfall ones. m_tvalid
// rises on the cycle after the output register load.
// The output register is separate from the working record, so a new beat
// is accepted while the previous result still waits on m_tready; a stalled
// receiver holds the block only when the next result is ready to be loaded.
// Synchronous reset returns the registers to their defaults, reseeds the
// generator and empties the output register.
module particle_euler_update #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [peu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [peu_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, age, max_age, zero pad
    input  logic [peu_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z, new_age
    output logic [peu_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // respawned
    output logic                               m_tuser,
    output logic                               m_tlast
);
    import peu_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    peu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    peu_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // The block is not ready again in the cycle after it accepts a beat.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on two consecutive cycles");

    // A result may only enter the output register when it is empty or draining.
    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while held");

    // The working record is only loaded on an accepted beat.
    a_load_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (s_tvalid && s_tready))
        else $error("record loaded without an accepted beat");

    // Loading the output register always raises m_tvalid on the next cycle.
    a_valid_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("result loaded but not presented");

endmodule

[sim/peu_checker.sv]
module peu_checker #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [peu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [peu_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [peu_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [peu_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               m_tuser,
    input  logic                               m_tlast,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 results_checked,
    output int                                 respawns_seen
);
    import peu_pkg::*;

    typedef struct packed {
        logic [6:0][31:0] vals;
        logic             respawned;
        logic             batch_end;
    } particle_update_t;

    // Shadow copy of the block's registers and generator.
    logic               cfg_mode;
    logic [16:0]        cfg_dt;
    logic [30:0]        cfg_width;
    logic signed [31:0] cfg_height;
    logic [30:0]        cfg_depth;
    logic signed [31:0] cfg_gravity;
    logic [16:0]        cfg_damp;
    logic [31:0]        xs_state;

    particle_update_t   expected_updates[$];
    string              field_names[7] = '{"new_pos_x", "new_pos_y", "new_pos_z",
                                           "new_vel_x", "new_vel_y", "new_vel_z", "new_age"};

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Arithmetic shift of a signed product rounds toward minus infinity.
    function automatic logic signed [31:0] fx_mul(input longint a, input longint b);
        return clamp32((a * b) >>> FRAC_BITS);
    endfunction

    function automatic logic [31:0] xs_next(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return (t == '0) ? RNG_DEFAULT : t;
    endfunction

    // Top 24 bits of a draw, centered on zero, scaled by the spread.
    function automatic longint spread_off(input logic [31:0] draw, input logic [30:0] spread);
        longint u;
        u = longint'(draw[31:8]) - 64'sd8388608;
        return (u * longint'(spread)) >>> DRAW_SHIFT;
    endfunction

    function automatic particle_update_t advance_particle(input logic [IN_TDATA_W-1:0] rec,
                                                          input logic last);
        longint px, py, pz, vx, vy, vz, age_v, age_lim, dt;
        particle_update_t r;
        px      = longint'($signed(rec[31:0]));
        py      = longint'($signed(rec[63:32]));
        pz      = longint'($signed(rec[95:64]));
        vx      = longint'($signed(rec[127:96]));
        vy      = longint'($signed(rec[159:128]));
        vz      = longint'($signed(rec[191:160]));
        age_v   = longint'($signed(rec[223:192]));
        age_lim = longint'(rec[254:224]);
        dt      = longint'(cfg_dt);
        r.respawned = 1'b0;
        r.batch_end = last;
        if (dt != 0) begin
            px = clamp32(px + fx_mul(vx, dt));
            py = clamp32(py + fx_mul(vy, dt));
            pz = clamp32(pz + fx_mul(vz, dt));
            if (!cfg_mode) begin
                if (py < 0) begin
                    // x is drawn before z.
                    py = cfg_height;
                    xs_state = xs_next(xs_state);
                    px = spread_off(xs_state, cfg_width);
                    xs_state = xs_next(xs_state);
                    pz = spread_off(xs_state, cfg_depth);
                    r.respawned = 1'b1;
                end
            end else begin
                vy = clamp32(vy + fx_mul(cfg_gravity, dt));
                vx = fx_mul(vx, longint'(cfg_damp));
                vy = fx_mul(vy, longint'(cfg_damp));
                vz = fx_mul(vz, longint'(cfg_damp));
                age_v = clamp32(age_v + dt);
                if (age_v >= age_lim) begin
                    age_v = -(longint'(1) << FRAC_BITS);
                end
            end
        end
        r.vals[0] = px[31:0];
        r.vals[1] = py[31:0];
        r.vals[2] = pz[31:0];
        r.vals[3] = vx[31:0];
        r.vals[4] = vy[31:0];
        r.vals[5] = vz[31:0];
        r.vals[6] = age_v[31:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("mismatch on result beat %0d: %s got %h expected %h",
                 results_checked, what, got, want);
    endtask

    always @(posedge aclk) begin
        particle_update_t want;
        if (!aresetn) begin
            cfg_mode    = RST_MODE;
            cfg_dt      = RST_TIME_STEP;
            cfg_width   = RST_SPAWN_WIDTH;
            cfg_height  = RST_SPAWN_HEIGHT;
            cfg_depth   = RST_SPAWN_DEPTH;
            cfg_gravity = RST_GRAVITY_Y;
            cfg_damp    = RST_DAMPING;
            xs_state    = RNG_DEFAULT;
            expected_updates.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    REG_MODE:         cfg_mode    = cfg_wdata[0];
                    REG_TIME_STEP:    cfg_dt      = cfg_wdata[16:0];
                    REG_SPAWN_WIDTH:  cfg_width   = cfg_wdata[30:0];
                    REG_SPAWN_HEIGHT: cfg_height  = cfg_wdata;
                    REG_SPAWN_DEPTH:  cfg_depth   = cfg_wdata[30:0];
                    REG_GRAVITY_Y:    cfg_gravity = cfg_wdata;
                    REG_DAMPING:      cfg_damp    = cfg_wdata[16:0];
                    REG_RNG_SEED:     xs_state    = (cfg_wdata == '0) ? RNG_DEFAULT : cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_updates.push_back(advance_particle(s_tdata, s_tlast));
            end
            if (m_tvalid && m_tready) begin
                if (expected_updates.size() == 0) begin
                    report_mismatch("beat with no particle outstanding, new_pos_x",
                                    m_tdata[31:0], '0);
                end else begin
                    want = expected_updates.pop_front();
                    for (int k = 0; k < 7; k++) begin
                        if (m_tdata[32*k +: 32] !== want.vals[k]) begin
                            report_mismatch(field_names[k], m_tdata[32*k +: 32], want.vals[k]);
                        end
                    end
                    if (m_tuser !== want.respawned) begin
                        report_mismatch("respawned", {31'b0, m_tuser}, {31'b0, want.respawned});
                    end
                    if (m_tlast !== want.batch_end) begin
                        report_mismatch("batch_end", {31'b0, m_tlast}, {31'b0, want.batch_end});
                    end
                    if (want.respawned) begin
                        respawns_seen++;
                    end
                end
                results_checked++;
            end
        end
        pending <= expected_updates.size();
    end

endmodule

[sim/particle_euler_update_tb.sv]
module particle_euler_update_tb;
    import peu_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          SEGMENTS    = 14;
    localparam int          SEG_ITEMS   = 50;
    localparam logic [31:0] Q_ONE       = 32'h0001_0000;
    localparam logic [31:0] DEAD_AGE    = 32'hFFFF_0000;
    localparam logic [31:0] S32_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN     = 32'h8000_0000;

    typedef struct packed {
        logic [30:0] max_age;
        logic [31:0] age;
        logic [31:0] vel_z;
        logic [31:0] vel_y;
        logic [31:0] vel_x;
        logic [31:0] pos_z;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } particle_t;

    typedef struct {
        logic        mode;
        logic [31:0] time_step;
        logic [31:0] spawn_width;
        logic [31:0] spawn_height;
        logic [31:0] spawn_depth;
        logic [31:0] gravity_y;
        logic [31:0] damping;
        logic [31:0] rng_seed;
    } setup_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_TDATA_W-1:0]    s_tdata;
    logic                     s_tlast;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_TDATA_W-1:0]   m_tdata;
    logic                     m_tuser;
    logic                     m_tlast;

    int fail_count;
    int pending;
    int results_checked;
    int respawns_seen;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req    = 1'b0;
    int items_sent  = 0;
    int setups_used = 0;
    int cycles      = 0;

    particle_euler_update dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    peu_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .respawns_seen   (respawns_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout with %0d result beats outstanding", pending);
        $display("FAIL particle_euler_update");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        int held;
        held = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && held < HOLD_CYCLES) begin
                m_tready <= 1'b0;
                held++;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic particle_t mk(input logic [31:0] px, py, pz, vx, vy, vz, age_v,
                                     input logic [30:0] age_lim);
        particle_t p;
        p = '{max_age: age_lim, age: age_v, vel_z: vz, vel_y: vy, vel_x: vx,
              pos_z: pz, pos_y: py, pos_x: px};
        return p;
    endfunction

    function automatic logic [31:0] rand_q();
        case ($urandom_range(9))
            0, 1:    return $urandom();
            2:       return $urandom_range(1) ? S32_MAX : S32_MIN;
            default: return $urandom_range(40 * 65536) - 20 * 65536;
        endcase
    endfunction

    function automatic particle_t rand_particle();
        particle_t p;
        p.pos_x = rand_q();
        p.pos_y = rand_q();
        p.pos_z = rand_q();
        p.vel_x = rand_q();
        p.vel_y = rand_q();
        p.vel_z = rand_q();
        case ($urandom_range(3))
            0:       p.max_age = 31'($urandom());
            1:       p.max_age = $urandom_range(1) ? '1 : '0;
            default: p.max_age = 31'($urandom_range(8 * 65536));
        endcase
        // Ages are mostly placed at or just short of the limit so particles die often.
        case ($urandom_range(4))
            0:       p.age = $urandom();
            1:       p.age = DEAD_AGE;
            2:       p.age = {1'b0, p.max_age};
            default: p.age = {1'b0, p.max_age} - $urandom_range(2 * 65536);
        endcase
        return p;
    endfunction

    function automatic setup_t base_setup();
        setup_t c;
        c.mode         = RST_MODE;
        c.time_step    = 32'(RST_TIME_STEP);
        c.spawn_width  = 32'(RST_SPAWN_WIDTH);
        c.spawn_height = RST_SPAWN_HEIGHT;
        c.spawn_depth  = 32'(RST_SPAWN_DEPTH);
        c.gravity_y    = RST_GRAVITY_Y;
        c.damping      = 32'(RST_DAMPING);
        c.rng_seed     = RNG_DEFAULT;
        return c;
    endfunction

    function automatic logic [31:0] rand_spread();
        case ($urandom_range(4))
            0:       return S32_MAX;
            1:       return '0;
            2:       return $urandom();
            default: return $urandom_range(20 * 65536);
        endcase
    endfunction

    function automatic logic [31:0] rand_signed_reg();
        case ($urandom_range(4))
            0:       return S32_MAX;
            1:       return S32_MIN;
            2:       return $urandom();
            default: return $urandom_range(40 * 65536) - 20 * 65536;
        endcase
    endfunction

    function automatic setup_t rand_setup();
        setup_t c;
        c.mode = 1'($urandom_range(1));
        case ($urandom_range(7))
            0:       c.time_step = '0;
            1:       c.time_step = 32'd1;
            2:       c.time_step = Q_ONE;
            3:       c.time_step = 32'h0001_FFFF;
            4:       c.time_step = $urandom();
            default: c.time_step = $urandom_range(1, 8192);
        endcase
        c.spawn_width  = rand_spread();
        c.spawn_depth  = rand_spread();
        c.spawn_height = rand_signed_reg();
        c.gravity_y    = rand_signed_reg();
        case ($urandom_range(5))
            0:       c.damping = '0;
            1:       c.damping = Q_ONE;
            2:       c.damping = 32'h0001_FFFF;
            3:       c.damping = $urandom();
            default: c.damping = $urandom_range(60000, 65536);
        endcase
        case ($urandom_range(3))
            0:       c.rng_seed = '0;
            1:       c.rng_seed = '1;
            default: c.rng_seed = $urandom();
        endcase
        return c;
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic apply_setup(input setup_t c);
        write_reg(REG_MODE,         {31'b0, c.mode});
        write_reg(REG_TIME_STEP,    c.time_step);
        write_reg(REG_SPAWN_WIDTH,  c.spawn_width);
        write_reg(REG_SPAWN_HEIGHT, c.spawn_height);
        write_reg(REG_SPAWN_DEPTH,  c.spawn_depth);
        write_reg(REG_GRAVITY_Y,    c.gravity_y);
        write_reg(REG_DAMPING,      c.damping);
        write_reg(REG_RNG_SEED,     c.rng_seed);
        cfg_wr_en <= 1'b0;
        setups_used++;
    endtask

    // Holds the input side idle until every outstanding result has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Returns at the edge on which the beat was accepted; s_tvalid stays high.
    task automatic send_particle(input particle_t p, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, p};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    initial begin
        setup_t c;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Waterfall with the reset register values.
        send_particle(mk('0, '0, '0, '0, '0, '0, '0, '0), 1'b0);
        send_particle(mk(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, '1), 1'b1);
        send_particle(mk(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, '0), 1'b0);
        send_particle(mk(Q_ONE, 32'd10, Q_ONE, '0, DEAD_AGE, '0, Q_ONE, 31'd65536), 1'b0);
        send_particle(mk(Q_ONE, 32'd1092, Q_ONE, '0, DEAD_AGE, '0, '0, 31'd1), 1'b0);
        send_particle(mk('0, '0, '0, '1, '0, '1, '0, '0), 1'b1);
        send_particle(mk($urandom(), 32'hFFFF_FFFF, $urandom(), $urandom(), '0, $urandom(),
                         $urandom(), 31'($urandom())), 1'b0);

        // Splash with a full second step, strongest downward gravity, no damping loss.
        wait_drained();
        c = base_setup();
        c.mode = 1'b1;
        c.time_step = Q_ONE;
        c.gravity_y = S32_MIN;
        c.damping = Q_ONE;
        apply_setup(c);
        send_particle(mk('0, '0, '0, Q_ONE, S32_MIN, DEAD_AGE, '0, 31'd655360), 1'b0);
        send_particle(mk('0, '0, '0, '0, '0, '0, 32'd589824, 31'd655360), 1'b1);
        send_particle(mk('0, '0, '0, '0, '0, '0, DEAD_AGE, 31'h7FFF_FFFF), 1'b0);
        send_particle(mk('0, '0, '0, '0, '0, '0, DEAD_AGE, '0), 1'b0);
        send_particle(mk('0, '0, '0, S32_MAX, S32_MAX, S32_MAX, S32_MAX, '1), 1'b1);

        // Time step and damping beyond one, strongest upward gravity.
        wait_drained();
        c.time_step = 32'h0001_FFFF;
        c.damping = 32'h0001_FFFF;
        c.gravity_y = S32_MAX;
        apply_setup(c);
        send_particle(mk(S32_MAX, '0, S32_MIN, S32_MAX, S32_MAX, S32_MIN, '0, '1), 1'b0);
        send_particle(mk('0, '0, '0, DEAD_AGE, DEAD_AGE, DEAD_AGE, '0, 31'd1), 1'b1);

        // A zero time step passes even a sunken particle through.
        wait_drained();
        c = base_setup();
        c.time_step = '0;
        apply_setup(c);
        send_particle(mk(Q_ONE, DEAD_AGE, Q_ONE, Q_ONE, DEAD_AGE, Q_ONE, '0, '0), 1'b1);
        send_particle(rand_particle(), 1'b0);

        // Respawns at the widest spread, lowest spawn height, zero seed.
        wait_drained();
        c = base_setup();
        c.spawn_width = S32_MAX;
        c.spawn_depth = S32_MAX;
        c.spawn_height = S32_MIN;
        c.rng_seed = '0;
        apply_setup(c);
        send_particle(mk('0, DEAD_AGE, '0, '0, '0, '0, '0, '0), 1'b0);
        send_particle(mk('0, S32_MIN, '0, '0, S32_MIN, '0, '0, '0), 1'b1);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg < 5) begin
                tx_idle_pct = 33;
                rx_idle_pct = 88;
            end else if (seg < 10) begin
                tx_idle_pct = 88;
                rx_idle_pct = 33;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            wait_drained();
            apply_setup(rand_setup());
            // With the receiver held off the block backs up onto its input.
            if (seg == 10) begin
                hold_req = 1'b1;
            end
            repeat (SEG_ITEMS) send_particle(rand_particle(), $urandom_range(3) == 0);
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Covered %0d particles over %0d register setups in %0d cycles.",
                 items_sent, setups_used, cycles);
        $display("Checked %0d result beats, %0d of them respawns; %0d mismatches.",
                 results_checked, respawns_seen, fail_count);
        if (fail_count == 0) begin
            $display("PASS particle_euler_update");
        end else begin
            $display("FAIL particle_euler_update");
        end
        $finish;
    end

endmodule
